@@ hdl/assert_macros.svh @@
// Assertion helper macros for the transform composer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/mtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transform composer package
// Shared types, constants and state encoding for the matrix composer.
// ----------------------------------------------------------------------------
package mtc_pkg;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] CMD_IDENTITY = 3'd0;
  localparam logic [2:0] CMD_TRANSLATE = 3'd1;
  localparam logic [2:0] CMD_SCALE = 3'd2;
  localparam logic [2:0] CMD_ROTATE = 3'd3;
  localparam logic [2:0] CMD_ORTHO = 3'd4;

  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] TWO_PI_Q60 = 64'sh6487ED5110B4611B;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam int CORDIC_STEPS = 30;

  typedef struct packed {
    logic [2:0] command;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_e;
    logic signed [31:0] arg_f;
  } request_t;

  typedef struct packed {
    logic [3:0] element_index;
    logic signed [31:0] element_value;
    logic last_element;
    logic divide_fault;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_ANGLE, ST_CORDIC, ST_ROTBUILD, ST_DIVSTART,
    ST_DIVWAIT, ST_MAC, ST_WRITE, ST_EMIT
  } state_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 32'sd843314857;
      5'd1: atan_q30 = 32'sd497837829;
      5'd2: atan_q30 = 32'sd263043837;
      5'd3: atan_q30 = 32'sd133525159;
      5'd4: atan_q30 = 32'sd67021687;
      5'd5: atan_q30 = 32'sd33543516;
      5'd6: atan_q30 = 32'sd16775851;
      5'd7: atan_q30 = 32'sd8388437;
      5'd8: atan_q30 = 32'sd4194283;
      5'd9: atan_q30 = 32'sd2097149;
      default: atan_q30 = 32'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
    else if (v < -67'sh80000000) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

@@ hdl/mtc_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transform composer divider
// Restoring divider, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module mtc_divider
  import mtc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic go,
  input wire logic signed [33:0] num,
  input wire logic signed [33:0] den,
  output logic done,
  output logic signed [31:0] quo
);
  localparam int NW = 34 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [NW-1:0] quotient;
  logic [34:0] rem;
  logic [33:0] dmag;
  logic neg;
  logic zero_den;
  logic num_pos;
  logic num_neg;
  logic [CW-1:0] count;
  logic busy;
  logic [34:0] trial;
  logic [NW:0] qs;

  assign trial = {rem[33:0], dividend[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        count <= CW'(NW);
        rem <= '0;
        quotient <= '0;
        dividend <= NW'(num[33] ? -num : num) << FRAC_BITS;
        dmag <= den[33] ? 34'(-den) : 34'(den);
        neg <= num[33] ^ den[33];
        zero_den <= (den == '0);
        num_pos <= !num[33] && (num != '0);
        num_neg <= num[33];
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, dmag}) begin
          rem <= trial - {1'b0, dmag};
          quotient <= {quotient[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quotient <= {quotient[NW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qs = neg ? -{1'b0, quotient} : {1'b0, quotient};
    if (zero_den) quo = num_pos ? 32'sh7FFFFFFF : (num_neg ? 32'sh80000000 : 32'sh0);
    else quo = sat32(67'(signed'(qs)));
  end
endmodule
`default_nettype wire

@@ hdl/matrix_transform_composer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix transform composer
// Composes a 4x4 Q16.16 transform matrix with one request at a time.
// ----------------------------------------------------------------------------
// Identity, translate and scale run a setup step, 64 multiply-accumulate steps
// through one shared multiplier, a write step and 16 result elements. Rotate
// adds angle reduction, 30 CORDIC steps and the rotation build. Orthographic
// adds six serial divisions. An unknown command goes from setup straight to
// the 16 result elements. Results cannot be stalled; busy stays high until
// the last one.
`include "assert_macros.svh"
module matrix_transform_composer_top
  import mtc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire request_t request,
  output logic strobe,
  output result_t result
);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  state_t state, state_next;
  request_t req;
  logic signed [31:0] m [16];
  logic signed [31:0] r [16];
  logic signed [31:0] nm [16];
  logic fault;
  logic [4:0] step;
  logic [5:0] mac_idx;
  logic [2:0] div_idx;
  logic signed [63:0] ang;
  logic [31:0] ang_q;
  logic signed [31:0] cx, cy;
  logic signed [31:0] cz;
  logic flip;
  logic signed [49:0] acc;
  logic signed [31:0] cs, sn;

  // Shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_rnd;
  assign prod = mul_a * mul_b;
  assign prod_rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  logic div_go, div_done;
  logic signed [33:0] div_num, div_den;
  logic signed [31:0] div_quo;
  mtc_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Rotation build: one quantity per step through the multiplier.
  logic [4:0] rb;
  logic signed [31:0] tmp [9];
  logic signed [31:0] t;
  assign t = ONE - cs;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MAC) begin
      mul_a = m[{mac_idx[5:4], mac_idx[1:0]}];
      mul_b = r[{mac_idx[3:2], mac_idx[1:0]}];
    end else if (state == ST_ROTBUILD) begin
      case (rb)
        5'd0: begin mul_a = req.arg_a; mul_b = req.arg_a; end
        5'd1: begin mul_a = req.arg_a; mul_b = req.arg_b; end
        5'd2: begin mul_a = req.arg_a; mul_b = req.arg_c; end
        5'd3: begin mul_a = req.arg_b; mul_b = req.arg_b; end
        5'd4: begin mul_a = req.arg_b; mul_b = req.arg_c; end
        5'd5: begin mul_a = req.arg_c; mul_b = req.arg_c; end
        5'd6: begin mul_a = req.arg_a; mul_b = sn; end
        5'd7: begin mul_a = req.arg_b; mul_b = sn; end
        5'd8: begin mul_a = req.arg_c; mul_b = sn; end
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14: begin
          mul_a = tmp[4'(rb - 5'd9)]; mul_b = t;
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SETUP;
      ST_SETUP: begin
        case (req.command)
          CMD_IDENTITY, CMD_TRANSLATE, CMD_SCALE: state_next = ST_MAC;
          CMD_ROTATE: state_next = ST_ANGLE;
          CMD_ORTHO: state_next = ST_DIVSTART;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_ANGLE: if (step == 5'd4) state_next = ST_CORDIC;
      ST_CORDIC: if (step == 5'(CORDIC_STEPS - 1)) state_next = ST_ROTBUILD;
      ST_ROTBUILD: if (rb == 5'd14) state_next = ST_MAC;
      ST_DIVSTART: state_next = ST_DIVWAIT;
      ST_DIVWAIT: if (div_done) state_next = (div_idx == 3'd5) ? ST_MAC : ST_DIVSTART;
      ST_MAC: if (mac_idx == 6'd63) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_EMIT;
      ST_EMIT: if (step == 5'd15) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    strobe = (state == ST_EMIT);
    result.element_index = step[3:0];
    result.element_value = m[step[3:0]];
    result.last_element = (step == 5'd15);
    result.divide_fault = fault;
    div_go = (state == ST_DIVSTART);
    case (div_idx)
      3'd0: begin div_num = 34'(ONE) <<< 1; div_den = 34'(req.arg_b) - 34'(req.arg_d); end
      3'd1: begin div_num = -(34'(req.arg_b) + 34'(req.arg_d));
        div_den = 34'(req.arg_b) - 34'(req.arg_d); end
      3'd2: begin div_num = 34'(ONE) <<< 1; div_den = 34'(req.arg_a) - 34'(req.arg_c); end
      3'd3: begin div_num = -(34'(req.arg_a) + 34'(req.arg_c));
        div_den = 34'(req.arg_a) - 34'(req.arg_c); end
      3'd4: begin div_num = -(34'(ONE) <<< 1); div_den = 34'(req.arg_f) - 34'(req.arg_e); end
      default: begin div_num = -(34'(req.arg_f) + 34'(req.arg_e));
        div_den = 34'(req.arg_f) - 34'(req.arg_e); end
    endcase
  end

  // Angle reduction constants.
  localparam logic signed [63:0] TP =
    (TWO_PI_Q60 + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
  localparam logic [63:0] ANG_RECIP = (64'd1 << 32) / 64'(TP);
  localparam logic signed [63:0] PI30 = (PI_Q60 + (64'sd1 <<< 29)) >>> 30;
  localparam logic signed [63:0] TWO_PI30 = (TWO_PI_Q60 + (64'sd1 <<< 29)) >>> 30;
  localparam logic signed [63:0] HALF_PI30 = (PI_Q60 + (64'sd1 <<< 30)) >>> 31;

  logic signed [63:0] zred, zfold;
  logic flip_n;
  logic signed [31:0] dx, dy;
  logic signed [31:0] xr, yr;
  always_comb begin
    zred = ang <<< (30 - FRAC_BITS);
    if (zred > PI30) zred = zred - TWO_PI30;
    flip_n = 1'b0;
    zfold = zred;
    if (zred > HALF_PI30) begin zfold = zred - PI30; flip_n = 1'b1; end
    else if (zred < -HALF_PI30) begin zfold = zred + PI30; flip_n = 1'b1; end
    dx = cy >>> step;
    dy = cx >>> step;
    xr = (cx + (32'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    yr = (cy + (32'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? ONE : 32'sd0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          req <= request;
          fault <= 1'b0;
        end
        ST_SETUP: begin
          for (int i = 0; i < 16; i++) r[i] <= (i % 5 == 0) ? ONE : 32'sd0;
          step <= '0;
          mac_idx <= '0;
          div_idx <= '0;
          rb <= '0;
          acc <= '0;
          ang <= req.arg_d[31] ? -64'(req.arg_d) : 64'(req.arg_d);
          case (req.command)
            CMD_IDENTITY, CMD_ORTHO:
              for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? ONE : 32'sd0;
            CMD_TRANSLATE: begin r[3] <= req.arg_a; r[7] <= req.arg_b; r[11] <= req.arg_c; end
            CMD_SCALE: begin r[0] <= req.arg_a; r[5] <= req.arg_b; r[10] <= req.arg_c; end
            default: ;
          endcase
        end
        ST_ANGLE: begin
          step <= (step == 5'd4) ? 5'd0 : step + 1'b1;
          case (step)
            5'd0: ang_q <= 32'((64'(ang[31:0]) * ANG_RECIP) >> 32);
            5'd1: ang <= ang - $signed(64'(ang_q)) * TP;
            5'd2: if (ang >= TP) ang <= ang - TP;
            5'd3: if (req.arg_d[31] && ang != 64'sd0) ang <= TP - ang;
            default: begin
              cz <= zfold[31:0];
              flip <= flip_n;
              cx <= CORDIC_GAIN_Q30;
              cy <= '0;
            end
          endcase
        end
        ST_CORDIC: begin
          if (!cz[31]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - atan_q30(step);
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + atan_q30(step);
          end
          step <= (step == 5'(CORDIC_STEPS - 1)) ? 5'd0 : step + 1'b1;
        end
        ST_ROTBUILD: begin
          if (rb == 5'd0) begin
            cs <= flip ? -xr : xr;
            sn <= flip ? -yr : yr;
          end
          rb <= rb + 1'b1;
          if (rb <= 5'd8) tmp[rb[3:0]] <= sat32(67'(prod_rnd));
          if (rb == 5'd9) r[0] <= sat32(67'(cs) + 67'(sat32(67'(prod_rnd))));
          if (rb == 5'd10) begin
            r[1] <= sat32(67'(sat32(67'(prod_rnd))) - 67'(tmp[8]));
            r[4] <= sat32(67'(sat32(67'(prod_rnd))) + 67'(tmp[8]));
          end
          if (rb == 5'd11) begin
            r[2] <= sat32(67'(sat32(67'(prod_rnd))) + 67'(tmp[7]));
            r[8] <= sat32(67'(sat32(67'(prod_rnd))) - 67'(tmp[7]));
          end
          if (rb == 5'd12) r[5] <= sat32(67'(cs) + 67'(sat32(67'(prod_rnd))));
          if (rb == 5'd13) begin
            r[6] <= sat32(67'(sat32(67'(prod_rnd))) - 67'(tmp[6]));
            r[9] <= sat32(67'(sat32(67'(prod_rnd))) + 67'(tmp[6]));
          end
          if (rb == 5'd14) r[10] <= sat32(67'(cs) + 67'(sat32(67'(prod_rnd))));
        end
        ST_DIVWAIT: if (div_done) begin
          div_idx <= div_idx + 1'b1;
          case (div_idx)
            3'd0: r[0] <= div_quo;
            3'd1: r[3] <= div_quo;
            3'd2: r[5] <= div_quo;
            3'd3: r[7] <= div_quo;
            3'd4: r[10] <= div_quo;
            default: r[11] <= div_quo;
          endcase
          if (div_den == '0) fault <= 1'b1;
        end
        ST_MAC: begin
          mac_idx <= mac_idx + 1'b1;
          if (mac_idx[1:0] == 2'd3) begin
            nm[mac_idx[5:2]] <= sat32(67'(acc) + 67'(prod_rnd));
            acc <= '0;
          end else begin
            acc <= acc + 50'(prod_rnd);
          end
        end
        ST_WRITE: begin
          for (int i = 0; i < 16; i++) m[i] <= nm[i];
          step <= '0;
        end
        ST_EMIT: step <= step + 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_strobe_busy, strobe |-> busy, "Result strobe outside a request.")
  `ASSERT_CLK(a_no_accept_busy, (start && !busy) |=> busy, "Accepted request did not raise busy.")
  `ASSERT_CLK(a_last_idle, (strobe && result.last_element) |=> !busy,
    "Block still busy after the last element.")
endmodule
`default_nettype wire

@@ tb/matrix_transform_composer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix transform composer testbench
// Sends transform requests, predicts the composed matrix for each one, and
// compares all sixteen emitted elements against the prediction.
// ----------------------------------------------------------------------------
module matrix_transform_composer_top_tb;
  import mtc_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic strobe;
  result_t result;

  longint matrix_now [16];
  result_t pending_elements [$];
  bit failed = 1'b0;
  bit sender_gaps = 1'b1;

  matrix_transform_composer_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .strobe(strobe), .result(result)
  );

  always #5 clk = ~clk;

  function automatic longint fshift(longint v, int s);
    if (v < 0) return -1 - ((-1 - v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    if (s == 0) return v;
    return fshift(v + (64'sd1 << (s - 1)), s);
  endfunction

  function automatic longint clip32(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return clip32(rshift(a * b, FB));
  endfunction

  function automatic longint fdiv(longint num, longint den, ref bit fault);
    if (den == 0) begin
      fault = 1'b1;
      if (num > 0) return SMAX;
      if (num < 0) return SMIN;
      return 0;
    end
    return clip32((num * ONE) / den);
  endfunction

  function automatic void load_identity(ref longint m [16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
  endfunction

  function automatic void sine_cosine(longint theta, output longint cs,
                                      output longint sn);
    longint tp, pi30, two_pi30, half_pi30, z, x, y, dx, dy;
    bit flip;
    tp = rshift(TWO_PI_Q60, 60 - FB);
    pi30 = rshift(PI_Q60, 30);
    two_pi30 = rshift(TWO_PI_Q60, 30);
    half_pi30 = rshift(PI_Q60, 31);
    x = CORDIC_GAIN_Q30;
    y = 0;
    flip = 1'b0;
    z = theta % tp;
    if (z < 0) z += tp;
    z = z * (64'sd1 << (30 - FB));
    if (z > pi30) z -= two_pi30;
    if (z > half_pi30) begin
      z -= pi30;
      flip = 1'b1;
    end else if (z < -half_pi30) begin
      z += pi30;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
      end
    end
    x = rshift(x, 30 - FB);
    y = rshift(y, 30 - FB);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic void compose_with(longint r [16]);
    longint nxt [16];
    longint acc;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += rshift(matrix_now[j*4+k] * r[i*4+k], FB);
        nxt[j*4+i] = clip32(acc);
      end
    matrix_now = nxt;
  endfunction

  function automatic void predict_elements(request_t q);
    longint r [16];
    longint a, b, c, d, e, f, cs, sn, t;
    bit fault;
    result_t x;
    a = q.arg_a; b = q.arg_b; c = q.arg_c;
    d = q.arg_d; e = q.arg_e; f = q.arg_f;
    fault = 1'b0;
    load_identity(r);
    case (q.command)
      CMD_IDENTITY: load_identity(matrix_now);
      CMD_TRANSLATE: begin
        r[3] = a; r[7] = b; r[11] = c;
        compose_with(r);
      end
      CMD_SCALE: begin
        r[0] = a; r[5] = b; r[10] = c;
        compose_with(r);
      end
      CMD_ROTATE: begin
        sine_cosine(d, cs, sn);
        t = ONE - cs;
        r[0] = clip32(cs + fmul(fmul(a, a), t));
        r[1] = clip32(fmul(fmul(a, b), t) - fmul(c, sn));
        r[2] = clip32(fmul(fmul(a, c), t) + fmul(b, sn));
        r[4] = clip32(fmul(fmul(b, a), t) + fmul(c, sn));
        r[5] = clip32(cs + fmul(fmul(b, b), t));
        r[6] = clip32(fmul(fmul(b, c), t) - fmul(a, sn));
        r[8] = clip32(fmul(fmul(c, a), t) - fmul(b, sn));
        r[9] = clip32(fmul(fmul(b, c), t) + fmul(a, sn));
        r[10] = clip32(cs + fmul(fmul(c, c), t));
        compose_with(r);
      end
      CMD_ORTHO: begin
        r[0] = fdiv(2 * ONE, b - d, fault);
        r[3] = fdiv(-(b + d), b - d, fault);
        r[5] = fdiv(2 * ONE, a - c, fault);
        r[7] = fdiv(-(a + c), a - c, fault);
        r[10] = fdiv(-2 * ONE, f - e, fault);
        r[11] = fdiv(-(f + e), f - e, fault);
        load_identity(matrix_now);
        compose_with(r);
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) begin
      x.element_index = i[3:0];
      x.element_value = matrix_now[i][31:0];
      x.last_element = (i == 15);
      x.divide_fault = fault;
      pending_elements.push_back(x);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_elements.size() == 0) begin
        $error("unexpected element index %0d", result.element_index);
        failed <= 1'b1;
      end else begin
        want = pending_elements.pop_front();
        if (result.element_index !== want.element_index) begin
          $error("element_index: expected %0d, got %0d",
                 want.element_index, result.element_index);
          failed <= 1'b1;
        end
        if (result.element_value !== want.element_value) begin
          $error("element_value[%0d]: expected %0d, got %0d", want.element_index,
                 want.element_value, result.element_value);
          failed <= 1'b1;
        end
        if (result.last_element !== want.last_element) begin
          $error("last_element: expected %0b, got %0b",
                 want.last_element, result.last_element);
          failed <= 1'b1;
        end
        if (result.divide_fault !== want.divide_fault) begin
          $error("divide_fault: expected %0b, got %0b",
                 want.divide_fault, result.divide_fault);
          failed <= 1'b1;
        end
      end
    end
  end

  task automatic send_request(request_t q);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end else begin
      @(posedge clk);
    end
    request <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_elements(q);
    start <= 1'b0;
  endtask

  function automatic request_t make_request(logic [2:0] cmd, longint a, longint b,
                                            longint c, longint d, longint e,
                                            longint f);
    request_t q;
    q.command = cmd;
    q.arg_a = a[31:0]; q.arg_b = b[31:0]; q.arg_c = c[31:0];
    q.arg_d = d[31:0]; q.arg_e = e[31:0]; q.arg_f = f[31:0];
    return q;
  endfunction

  function automatic longint modest_value();
    return longint'($signed($urandom_range(0, 4 * ONE))) - 2 * ONE;
  endfunction

  function automatic request_t random_request();
    request_t q;
    q = make_request(3'($urandom_range(CMD_IDENTITY, CMD_ORTHO)), modest_value(),
                     modest_value(), modest_value(), $signed($urandom_range(0, 14 * ONE)) - 7 * ONE,
                     modest_value(), modest_value());
    if ($urandom_range(0, 9) == 0) q.command = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    if ($urandom_range(0, 5) == 0) begin
      q.arg_a = $urandom; q.arg_b = $urandom; q.arg_c = $urandom;
      q.arg_d = $urandom; q.arg_e = $urandom; q.arg_f = $urandom;
    end
    if (q.command == CMD_ORTHO && $urandom_range(0, 7) == 0) q.arg_e = q.arg_f;
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_elements.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_commands();
    send_request(make_request(CMD_TRANSLATE, 3 * ONE, -2 * ONE, ONE / 2, 0, 0, 0));
    send_request(make_request(CMD_SCALE, 2 * ONE, ONE / 4, -ONE, 0, 0, 0));
    send_request(make_request(CMD_ROTATE, 0, 0, ONE, 102944, 0, 0));
    send_request(make_request(CMD_ROTATE, ONE, 0, 0, -4 * ONE, 0, 0));
    send_request(make_request(CMD_ROTATE, 0, ONE, 0, SMAX, 0, 0));
    send_request(make_request(CMD_ROTATE, ONE, ONE, ONE, SMIN, 0, 0));
    send_request(make_request(CMD_IDENTITY, 5, 6, 7, 8, 9, 10));
    send_request(make_request(CMD_ORTHO, ONE, ONE, -ONE, -ONE, ONE / 10, 100 * ONE));
    send_request(make_request(CMD_BAD_LO, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_BAD_HI, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_extremes();
    send_request(make_request(CMD_IDENTITY, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_SCALE, SMAX, SMIN, SMAX, 0, 0, 0));
    send_request(make_request(CMD_SCALE, SMAX, SMAX, SMIN, 0, 0, 0));
    send_request(make_request(CMD_TRANSLATE, SMIN, SMAX, -1, 0, 0, 0));
    send_request(make_request(CMD_ROTATE, SMAX, SMIN, SMAX, ONE, 0, 0));
    send_request(make_request(CMD_ROTATE, 2 * ONE, 3 * ONE, 0, 0, 0, 0));
  endtask

  task automatic test_zero_planes();
    send_request(make_request(CMD_ORTHO, ONE, ONE, ONE, ONE, ONE, ONE));
    send_request(make_request(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_ORTHO, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX));
    send_request(make_request(CMD_ORTHO, -ONE, 3 * ONE, ONE, -3 * ONE, 2 * ONE, 2 * ONE));
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 130; n++) begin
      if (n == 60) wait_drained();
      if (n == 110) sender_gaps = 1'b0;
      send_request(random_request());
    end
  endtask

  initial begin
    matrix_now = '{default: 0};
    load_identity(matrix_now);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_commands();
    test_extremes();
    test_zero_planes();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (300) @(posedge clk);
    if (!failed && pending_elements.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
